// ===== rtl/core/foas_pkg.sv =====
// Shared types, constants and CORDIC angle table for the offset-follow steering block.
package foas_pkg;

  localparam int ITER      = 18;  // CORDIC steps, both rotation and vectoring
  localparam int ANG_W     = 26;  // angle width, degrees * 32768
  localparam int SC_W      = 33;  // rotation x/y, Q2.30
  localparam int AT_W      = 45;  // vectoring x/z after normalization
  localparam int NM_W      = 42;  // normalization magnitude
  localparam int SQ_STEPS  = 24;  // square root result bits
  localparam int SQ_W      = 48;  // square root radicand
  localparam int DIV_STEPS = 16;  // quotient bits
  localparam int NUM_W     = 40;  // ramp numerator
  localparam int CFG_IDX_W = 3;
  localparam int FAR       = 131071;

  localparam logic signed [ANG_W-1:0] DEG90  = 26'sd2949120;
  localparam logic signed [ANG_W-1:0] DEG180 = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG360 = 26'sd11796480;
  localparam logic signed [SC_W-1:0]  KQ30   = 33'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOW_RADIUS   = 3'd0,
    REG_STOP_DISTANCE = 3'd1,
    REG_MAX_SPEED     = 3'd2,
    REG_OFFSET_X      = 3'd3,
    REG_OFFSET_Z      = 3'd4
  } reg_idx_t;

  // atan(2^-i) in degrees * 32768
  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    case (i)
      0:  return 26'sd1474560;
      1:  return 26'sd870484;
      2:  return 26'sd459940;
      3:  return 26'sd233473;
      4:  return 26'sd117189;
      5:  return 26'sd58652;
      6:  return 26'sd29333;
      7:  return 26'sd14667;
      8:  return 26'sd7334;
      9:  return 26'sd3667;
      10: return 26'sd1833;
      11: return 26'sd917;
      12: return 26'sd458;
      13: return 26'sd229;
      14: return 26'sd115;
      15: return 26'sd57;
      16: return 26'sd29;
      17: return 26'sd14;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== rtl/core/follow_offset_arrive_steering.sv =====
// Offset-follow steering: pipelined sin/cos, offset rotation, atan2, sqrt ramp and divide.
// Throughput: one word per cycle while busy is low; every stage advances each cycle, no stall.
// The depth is set by the square root (24 stages) and divider (16 stages) chain.
// Reset clears the valid line and loads the register defaults; busy is high in reset.
// done marks each result for one cycle; the receiver cannot stall the block.
module follow_offset_arrive_steering #(
  parameter int POS_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [POS_BITS-1:0]       leader_x,
  input  logic signed [POS_BITS-1:0]       leader_y,
  input  logic signed [POS_BITS-1:0]       leader_z,
  input  logic signed [15:0]               leader_heading,
  input  logic signed [POS_BITS-1:0]       self_x,
  input  logic signed [POS_BITS-1:0]       self_y,
  input  logic signed [POS_BITS-1:0]       self_z,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [foas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data,
  output logic                             done,
  output logic signed [15:0]               desired_heading,
  output logic [15:0]                      desired_speed,
  output logic                             arrived
);
  import foas_pkg::*;

  localparam int RW  = POS_BITS + 1;  // raw difference
  localparam int DW  = POS_BITS + 2;  // difference plus rotated offset
  localparam int LAT = 66;

  // configuration
  logic [15:0]        slow_radius, stop_distance, max_speed;
  logic signed [15:0] offset_x, offset_z;
  logic [31:0]        slow_sq, stop_sq;
  logic [23:0]        den;
  logic               slow_gt_stop;

  logic [LAT-1:0] vld;

  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b1;
      slow_radius   <= 16'd300;
      stop_distance <= 16'd10;
      max_speed     <= 16'd100;
      offset_x      <= -16'sd100;
      offset_z      <= 16'sd0;
      vld           <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LAT-2:0], start & ~busy};
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLOW_RADIUS:   slow_radius   <= cfg_data;
          REG_STOP_DISTANCE: stop_distance <= cfg_data;
          REG_MAX_SPEED:     max_speed     <= cfg_data;
          REG_OFFSET_X:      offset_x      <= cfg_data;
          REG_OFFSET_Z:      offset_z      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    slow_sq      <= slow_radius * slow_radius;
    stop_sq      <= stop_distance * stop_distance;
    den          <= {slow_radius - stop_distance, 8'h00};
    slow_gt_stop <= slow_radius > stop_distance;
  end

  // ---------------- stage 1: angle fold and raw differences
  logic signed [ANG_W-1:0] na, nw, a0;
  logic                    neg0;
  logic signed [RW-1:0]    rdx, rdy, rdz;

  always_comb begin
    na = ANG_W'(-(ANG_W'(leader_heading) <<< 8));
    nw = na;
    if (na > DEG180) begin
      nw = na - DEG360;
    end else if (na <= -DEG180) begin
      nw = na + DEG360;
    end
    a0   = nw;
    neg0 = 1'b0;
    if (nw > DEG90) begin
      a0   = nw - DEG180;
      neg0 = 1'b1;
    end else if (nw < -DEG90) begin
      a0   = nw + DEG180;
      neg0 = 1'b1;
    end
    rdx = RW'(leader_x) - RW'(self_x);
    rdy = RW'(leader_y) - RW'(self_y);
    rdz = RW'(leader_z) - RW'(self_z);
  end

  // ---------------- sin/cos rotation CORDIC, stages 1..19
  logic signed [SC_W-1:0]  cx [0:ITER];
  logic signed [SC_W-1:0]  cy [0:ITER];
  logic signed [ANG_W-1:0] ca [0:ITER];
  logic                    cn [0:ITER];

  always_ff @(posedge clk) begin
    cx[0] <= KQ30;
    cy[0] <= '0;
    ca[0] <= a0;
    cn[0] <= neg0;
    for (int i = 0; i < ITER; i++) begin
      cn[i+1] <= cn[i];
      if (ca[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        ca[i+1] <= ca[i] - atan_step(i);
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        ca[i+1] <= ca[i] + atan_step(i);
      end
    end
  end

  // raw differences ride along until the offset is added
  logic signed [RW-1:0] rdx_d [1:21];
  logic signed [RW-1:0] rdy_d [1:21];
  logic signed [RW-1:0] rdz_d [1:21];

  always_ff @(posedge clk) begin
    rdx_d[1] <= rdx;
    rdy_d[1] <= rdy;
    rdz_d[1] <= rdz;
    for (int i = 2; i <= 21; i++) begin
      rdx_d[i] <= rdx_d[i-1];
      rdy_d[i] <= rdy_d[i-1];
      rdz_d[i] <= rdz_d[i-1];
    end
  end

  // ---------------- arrival on the raw vector, stages 2..3
  logic [RW-1:0] rax, ray, raz;
  logic [33:0]   rsx, rsy, rsz;
  logic          rfar;
  logic [35:0]   r2;
  logic          arr_d [0:62];

  always_comb begin
    rax = rdx_d[1][RW-1] ? RW'(-rdx_d[1]) : RW'(rdx_d[1]);
    ray = rdy_d[1][RW-1] ? RW'(-rdy_d[1]) : RW'(rdy_d[1]);
    raz = rdz_d[1][RW-1] ? RW'(-rdz_d[1]) : RW'(rdz_d[1]);
    r2  = 36'(rsx) + 36'(rsy) + 36'(rsz);
  end

  always_ff @(posedge clk) begin
    rfar     <= (rax > RW'(FAR)) || (ray > RW'(FAR)) || (raz > RW'(FAR));
    rsx      <= rax[16:0] * rax[16:0];
    rsy      <= ray[16:0] * ray[16:0];
    rsz      <= raz[16:0] * raz[16:0];
    arr_d[0] <= !rfar && (r2 <= 36'(stop_sq));
    for (int i = 1; i <= 62; i++) begin
      arr_d[i] <= arr_d[i-1];
    end
  end

  // ---------------- stage 20: round sin/cos to Q1.15
  logic signed [SC_W-1:0] xs, ys, xr, yr;
  logic signed [15:0]     cq, sq;

  always_comb begin
    xs = cn[ITER] ? -cx[ITER] : cx[ITER];
    ys = cn[ITER] ? -cy[ITER] : cy[ITER];
    xr = (xs + 33'sd16384) >>> 15;
    yr = (ys + 33'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (xr > 33'sd32767) begin
      cq <= 16'sd32767;
    end else if (xr < -33'sd32768) begin
      cq <= -16'sd32768;
    end else begin
      cq <= 16'(xr);
    end
    if (yr > 33'sd32767) begin
      sq <= 16'sd32767;
    end else if (yr < -33'sd32768) begin
      sq <= -16'sd32768;
    end else begin
      sq <= 16'(yr);
    end
  end

  // ---------------- stage 21: offset products
  logic signed [31:0] pxc, pzs, pxs, pzc;

  always_ff @(posedge clk) begin
    pxc <= offset_x * cq;
    pzs <= offset_z * sq;
    pxs <= offset_x * sq;
    pzc <= offset_z * cq;
  end

  // ---------------- stage 22: rotated offset plus difference
  logic signed [33:0] rxs, rzs;
  logic signed [17:0] rx, rz;
  logic signed [DW-1:0] dx, dy, dz;

  always_comb begin
    rxs = 34'(pxc) - 34'(pzs) + 34'sd16384;
    rzs = 34'(pxs) + 34'(pzc) + 34'sd16384;
    rx  = 18'(rxs >>> 15);
    rz  = 18'(rzs >>> 15);
  end

  always_ff @(posedge clk) begin
    dx <= DW'(rdx_d[21]) + DW'(rx);
    dy <= DW'(rdy_d[21]);
    dz <= DW'(rdz_d[21]) + DW'(rz);
  end

  // ---------------- stage 23: magnitudes for normalization and distance
  logic [DW-1:0] ax, ay, az;

  always_comb begin
    ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
    az = dz[DW-1] ? DW'(-dz) : DW'(dz);
  end

  // ---------------- atan2 path: normalize stages 24..26
  logic [NM_W-1:0]        nm  [0:3];
  logic signed [AT_W-1:0] nx  [0:3];
  logic signed [AT_W-1:0] nz  [0:3];
  logic                   nzr [0:3];
  logic [NM_W-1:0]        hm  [0:5];
  logic signed [AT_W-1:0] hx  [0:5];
  logic signed [AT_W-1:0] hz  [0:5];
  logic [NM_W-1:0]        tm;
  logic signed [AT_W-1:0] tx, tz;

  // two shift steps per stage: 32,16 then 8,4 then 2,1; the larger magnitude ends in 2^40..2^41
  always_comb begin
    tm = '0;
    tx = '0;
    tz = '0;
    for (int j = 0; j < 6; j++) begin
      if (j % 2 == 0) begin
        tm = nm[j/2];
        tx = nx[j/2];
        tz = nz[j/2];
      end else begin
        tm = hm[j-1];
        tx = hx[j-1];
        tz = hz[j-1];
      end
      if (tm < (NM_W'(1) << (41 - (32 >> j)))) begin
        hm[j] = tm << (32 >> j);
        hx[j] = tx <<< (32 >> j);
        hz[j] = tz <<< (32 >> j);
      end else begin
        hm[j] = tm;
        hx[j] = tx;
        hz[j] = tz;
      end
    end
  end

  always_ff @(posedge clk) begin
    nm[0]  <= NM_W'(ax | az);
    nx[0]  <= AT_W'(dx);
    nz[0]  <= AT_W'(dz);
    nzr[0] <= (dx == '0) && (dz == '0);
    for (int s = 0; s < 3; s++) begin
      nm[s+1]  <= hm[2*s+1];
      nx[s+1]  <= hx[2*s+1];
      nz[s+1]  <= hz[2*s+1];
      nzr[s+1] <= nzr[s];
    end
  end

  // ---------------- stage 27: half-plane fold, then vectoring 28..45
  logic signed [AT_W-1:0]  vx [0:ITER];
  logic signed [AT_W-1:0]  vz [0:ITER];
  logic signed [ANG_W-1:0] va [0:ITER];
  logic                    vzr [0:ITER];

  always_ff @(posedge clk) begin
    vzr[0] <= nzr[3];
    if (nx[3] < 0) begin
      va[0] <= (nz[3] >= 0) ? DEG180 : -DEG180;
      vx[0] <= -nx[3];
      vz[0] <= -nz[3];
    end else begin
      va[0] <= '0;
      vx[0] <= nx[3];
      vz[0] <= nz[3];
    end
    for (int i = 0; i < ITER; i++) begin
      vzr[i+1] <= vzr[i];
      if (vz[i] > 0) begin
        vx[i+1] <= vx[i] + (vz[i] >>> i);
        vz[i+1] <= vz[i] - (vx[i] >>> i);
        va[i+1] <= va[i] + atan_step(i);
      end else begin
        vx[i+1] <= vx[i] - (vz[i] >>> i);
        vz[i+1] <= vz[i] + (vx[i] >>> i);
        va[i+1] <= va[i] - atan_step(i);
      end
    end
  end

  // ---------------- stage 46: heading in 1/128 degree, held to stage 65
  logic signed [ANG_W:0] hv, hs;
  logic signed [15:0]    hdd [0:19];

  always_comb begin
    hv = -(27'(va[ITER])) + 27'sd128;
    hs = hv >>> 8;
  end

  always_ff @(posedge clk) begin
    if (vzr[ITER]) begin
      hdd[0] <= '0;
    end else if (hs > 27'sd23040) begin
      hdd[0] <= 16'sd23040;
    end else if (hs < -27'sd23040) begin
      hdd[0] <= -16'sd23040;
    end else begin
      hdd[0] <= 16'(hs);
    end
    for (int i = 1; i <= 19; i++) begin
      hdd[i] <= hdd[i-1];
    end
  end

  // ---------------- distance path: squares (23), range check (24)
  logic [33:0] dsx, dsy, dsz;
  logic        dfar;
  logic [35:0] d2;
  logic        inr;

  always_comb begin
    d2  = 36'(dsx) + 36'(dsy) + 36'(dsz);
    inr = !dfar && slow_gt_stop && (d2 <= 36'(slow_sq));
  end

  always_ff @(posedge clk) begin
    dfar <= (ax > DW'(FAR)) || (ay > DW'(FAR)) || (az > DW'(FAR));
    dsx  <= ax[16:0] * ax[16:0];
    dsy  <= ay[16:0] * ay[16:0];
    dsz  <= az[16:0] * az[16:0];
  end

  // ---------------- square root, one result bit per stage, 25..48
  logic [SQ_W-1:0] qn    [0:SQ_STEPS];
  logic [SQ_W-1:0] qr    [0:SQ_STEPS];
  logic            qramp [0:SQ_STEPS];
  logic [SQ_W-1:0] qt    [0:SQ_STEPS-1];

  always_comb begin
    for (int j = 0; j < SQ_STEPS; j++) begin
      qt[j] = qr[j] + (SQ_W'(1) << (SQ_W - 2 - 2*j));
    end
  end

  always_ff @(posedge clk) begin
    qn[0]    <= inr ? {d2[31:0], 16'h0000} : '0;
    qr[0]    <= '0;
    qramp[0] <= inr;
    for (int j = 0; j < SQ_STEPS; j++) begin
      qramp[j+1] <= qramp[j];
      if (qn[j] >= qt[j]) begin
        qn[j+1] <= qn[j] - qt[j];
        qr[j+1] <= (qr[j] >> 1) + (SQ_W'(1) << (SQ_W - 2 - 2*j));
      end else begin
        qn[j+1] <= qn[j];
        qr[j+1] <= qr[j] >> 1;
      end
    end
  end

  // ---------------- stage 49: ramp numerator
  logic [23:0] d8, stop8, dif;
  logic        le;

  always_comb begin
    d8    = qr[SQ_STEPS][23:0];
    stop8 = {stop_distance, 8'h00};
    le    = d8 <= stop8;
    dif   = d8 - stop8;
  end

  // ---------------- divider, one quotient bit per stage, 50..65
  logic [NUM_W-1:0]     dr    [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dq    [0:DIV_STEPS];
  logic                 dzsp  [0:DIV_STEPS];
  logic                 duseq [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    dr[0]    <= dif * max_speed;
    dq[0]    <= '0;
    dzsp[0]  <= qramp[SQ_STEPS] & le;
    duseq[0] <= qramp[SQ_STEPS] & ~le;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dzsp[k+1]  <= dzsp[k];
      duseq[k+1] <= duseq[k];
      if (dr[k] >= (NUM_W'(den) << (DIV_STEPS - 1 - k))) begin
        dr[k+1] <= dr[k] - (NUM_W'(den) << (DIV_STEPS - 1 - k));
        dq[k+1] <= dq[k] | (DIV_STEPS'(1) << (DIV_STEPS - 1 - k));
      end else begin
        dr[k+1] <= dr[k];
        dq[k+1] <= dq[k];
      end
    end
  end

  // ---------------- stage 66: result word
  always_ff @(posedge clk) begin
    desired_heading <= hdd[19];
    arrived         <= arr_d[62];
    if (arr_d[62] || dzsp[DIV_STEPS]) begin
      desired_speed <= '0;
    end else if (duseq[DIV_STEPS]) begin
      desired_speed <= dq[DIV_STEPS];
    end else begin
      desired_speed <= max_speed;
    end
  end

  assign done = vld[LAT-1];

  // ---------------- checks
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result word without a matching accepted word");

  a_arrived_stops: assert property (@(posedge clk) disable iff (rst)
    done && arrived |-> desired_speed == '0)
    else $error("arrived with nonzero speed");

  a_speed_limit: assert property (@(posedge clk) disable iff (rst)
    done |-> desired_speed <= max_speed)
    else $error("speed above max_speed");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (desired_heading >= -16'sd23040) && (desired_heading <= 16'sd23040))
    else $error("heading out of range");

endmodule

// ===== tb/follow_offset_arrive_steering_test.sv =====
// Self-checking testbench for the offset-follow steering block with arrival detection.
module follow_offset_arrive_steering_test;
  import foas_pkg::*;

  localparam int  PW       = 24;
  localparam int  STEPS    = 18;
  localparam int  LAT      = 66;
  localparam longint A90   = 2949120;
  localparam longint A180  = 5898240;
  localparam longint A360  = 11796480;
  localparam longint K30   = 652032874;
  localparam longint FAR_C = 131071;
  localparam longint ATAN_DEG [STEPS] = '{1474560, 870484, 459940, 233473, 117189, 58652,
    29333, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14};

  typedef struct {
    logic signed [PW-1:0] lx, ly, lz, sx, sy, sz;
    logic signed [15:0]   hd;
  } pose_t;

  typedef struct {
    logic signed [15:0] heading;
    logic [15:0]        speed;
    logic               arr;
  } steer_t;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done, arrived;
  logic signed [PW-1:0] leader_x, leader_y, leader_z, self_x, self_y, self_z;
  logic signed [15:0] leader_heading, desired_heading;
  logic [15:0] desired_speed, cfg_data;
  logic [CFG_IDX_W-1:0] cfg_index;

  // local copy of the register file
  longint slow_r, stop_r, max_r, offx_r, offz_r;
  steer_t expected_q[$];
  steer_t got;
  int errors;
  int n_results;
  int n_arrived;

  follow_offset_arrive_steering #(.POS_BITS(PW)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .leader_x(leader_x), .leader_y(leader_y), .leader_z(leader_z),
    .leader_heading(leader_heading),
    .self_x(self_x), .self_y(self_y), .self_z(self_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .desired_heading(desired_heading),
    .desired_speed(desired_speed), .arrived(arrived)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

  function automatic longint iabs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic bit sq_len(longint a, longint b, longint c, output longint d2);
    d2 = 0;
    if (iabs64(a) > FAR_C || iabs64(b) > FAR_C || iabs64(c) > FAR_C) return 1'b0;
    d2 = a * a + b * b + c * c;
    return 1'b1;
  endfunction

  // rotation-mode CORDIC, angle in degrees * 32768
  function automatic void cos_sin(longint a, output longint c, output longint s);
    longint x, y, xn;
    bit neg;
    x = K30;
    y = 0;
    neg = 1'b0;
    while (a > A180) a -= A360;
    while (a <= -A180) a += A360;
    if (a > A90) begin
      a -= A180;
      neg = 1'b1;
    end else if (a < -A90) begin
      a += A180;
      neg = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (a >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        a -= ATAN_DEG[i];
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        a += ATAN_DEG[i];
      end
      x = xn;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = clip((x + 16384) >>> 15, -32768, 32767);
    s = clip((y + 16384) >>> 15, -32768, 32767);
  endfunction

  // vectoring-mode CORDIC
  function automatic longint angle_of(longint z, longint x);
    longint ang, xn;
    ang = 0;
    if (x == 0 && z == 0) return 0;
    while (iabs64(x) < (64'sd1 <<< 40) && iabs64(z) < (64'sd1 <<< 40)) begin
      x *= 2;
      z *= 2;
    end
    if (x < 0) begin
      ang = (z >= 0) ? A180 : -A180;
      x = -x;
      z = -z;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z > 0) begin
        xn = x + (z >>> i);
        z  = z - (x >>> i);
        ang += ATAN_DEG[i];
      end else begin
        xn = x - (z >>> i);
        z  = z + (x >>> i);
        ang -= ATAN_DEG[i];
      end
      x = xn;
    end
    return ang;
  endfunction

  function automatic steer_t predict_steering(pose_t p);
    steer_t r;
    longint c, s, rx, rz, rdx, rdy, rdz, dx, dz, spd, d2, r2, d8;
    cos_sin(-longint'(p.hd) * 256, c, s);
    rx  = (offx_r * c - offz_r * s + 16384) >>> 15;
    rz  = (offx_r * s + offz_r * c + 16384) >>> 15;
    rdx = longint'(p.lx) - longint'(p.sx);
    rdy = longint'(p.ly) - longint'(p.sy);
    rdz = longint'(p.lz) - longint'(p.sz);
    dx  = rdx + rx;
    dz  = rdz + rz;
    r.heading = 16'(clip((-angle_of(dz, dx) + 128) >>> 8, -23040, 23040));
    spd = max_r;
    if (slow_r > stop_r && sq_len(dx, rdy, dz, d2) && d2 <= slow_r * slow_r) begin
      d8 = int_sqrt(longint'(d2) << 16);
      if (d8 <= stop_r * 256) spd = 0;
      else spd = clip(((d8 - stop_r * 256) * max_r) / ((slow_r - stop_r) * 256), 0, max_r);
    end
    r.arr = 1'b0;
    if (sq_len(rdx, rdy, rdz, r2) && r2 <= stop_r * stop_r) begin
      r.arr = 1'b1;
      spd = 0;
    end
    r.speed = 16'(spd);
    return r;
  endfunction

  // result checker: sample mid-cycle, one word per done strobe
  always @(negedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (arrived) n_arrived++;
      if (expected_q.size() == 0) begin
        $error("unexpected result word: heading %0d speed %0d arrived %0b",
               desired_heading, desired_speed, arrived);
        errors++;
      end else begin
        got = expected_q.pop_front();
        if (desired_heading !== got.heading) begin
          $error("desired_heading: expected %0d, actual %0d", got.heading, desired_heading);
          errors++;
        end
        if (desired_speed !== got.speed) begin
          $error("desired_speed: expected %0d, actual %0d", got.speed, desired_speed);
          errors++;
        end
        if (arrived !== got.arr) begin
          $error("arrived: expected %0b, actual %0b", got.arr, arrived);
          errors++;
        end
      end
    end
  end

  // called at a rising edge; returns at the accepting edge with start left high
  task automatic send_item(pose_t p);
    start          <= 1'b1;
    leader_x       <= p.lx;
    leader_y       <= p.ly;
    leader_z       <= p.lz;
    leader_heading <= p.hd;
    self_x         <= p.sx;
    self_y         <= p.sy;
    self_z         <= p.sz;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    expected_q.push_back(predict_steering(p));
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    case (idx)
      REG_SLOW_RADIUS:   slow_r = longint'(val);
      REG_STOP_DISTANCE: stop_r = longint'(val);
      REG_MAX_SPEED:     max_r  = longint'(val);
      REG_OFFSET_X:      offx_r = longint'($signed(val));
      REG_OFFSET_Z:      offz_r = longint'($signed(val));
      default: ;
    endcase
  endtask

  // hold until every word is back, then let the pipeline empty
  task automatic drain();
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  function automatic int srand(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic pose_t make_pose(int mode);
    pose_t p;
    int span;
    int lx, ly, lz;
    lx = srand(2000000);
    ly = srand(2000000);
    lz = srand(2000000);
    case ($urandom_range(0, 3))
      0: span = 16;
      1: span = 400;
      2: span = 3000;
      default: span = 200000;
    endcase
    if (mode == 1) span = 8;
    p.lx = PW'(lx);
    p.ly = PW'(ly);
    p.lz = PW'(lz);
    p.sx = PW'(lx + srand(span));
    p.sy = PW'(lz == 0 ? ly : ly + srand(span / 4));
    p.sz = PW'(lz + srand(span));
    if (mode == 2) begin
      p.lx = PW'($urandom);
      p.ly = PW'($urandom);
      p.lz = PW'($urandom);
      p.sx = PW'($urandom);
      p.sy = PW'($urandom);
      p.sz = PW'($urandom);
    end
    if ($urandom_range(0, 7) == 0) p.hd = 16'($urandom);
    else p.hd = 16'(int'($urandom_range(0, 46080)) - 23040);
    return p;
  endfunction

  task automatic run_random(int count, bit gaps);
    bit idle_on;
    int r;
    idle_on = gaps;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_on = gaps && ($urandom_range(0, 2) != 0);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      r = $urandom_range(0, 9);
      send_item(make_pose(r < 6 ? 0 : (r < 8 ? 1 : 2)));
    end
  endtask

  task automatic test_directed();
    pose_t p;
    p = '{default: '0};
    send_item(p);                      // on top of leader: arrived
    p.sx = -24'sd100;                  // offset cancels the gap: zero vector
    send_item(p);
    p.sx = 24'sd50;                    // pointing straight back: heading at minus 180
    send_item(p);
    p.sx = '0;
    p.hd = 16'sh7FFF;                  // heading beyond range wraps
    send_item(p);
    p.hd = 16'sh8000;
    send_item(p);
    p.hd = 16'sd23040;
    send_item(p);
    p.hd = -16'sd23040;
    send_item(p);
    p.hd = 16'sd11520;
    send_item(p);
    p = '{lx: 24'sh7FFFFF, ly: 24'sh7FFFFF, lz: 24'sh7FFFFF,
          sx: 24'sh800000, sy: 24'sh800000, sz: 24'sh800000, hd: 16'sd0};
    send_item(p);                      // far away
    p = '{lx: 24'sh800000, ly: 24'sh800000, lz: 24'sh800000,
          sx: 24'sh7FFFFF, sy: 24'sh7FFFFF, sz: 24'sh7FFFFF, hd: 16'sh5A00};
    send_item(p);
    p = '{lx: 24'sd1000, ly: 24'sd7, lz: 24'sd200, sx: 24'sd1000, sy: 24'sd0,
          sz: 24'sd195, hd: 16'sd0};
    send_item(p);                      // inside stop
    p.sz = 24'sd100;
    send_item(p);                      // on the ramp
    p.sx = 24'sd1000 - 24'sd131072;
    send_item(p);                      // component just past the far limit
    p = '{lx: 24'sd5, ly: 24'sd0, lz: 24'sd0, sx: 24'sd0, sy: 24'sd10, sz: 24'sd0,
          hd: -16'sd100};
    send_item(p);
    drain();
  endtask

  task automatic test_config(logic [15:0] slow, logic [15:0] stp, logic [15:0] mx,
                             logic [15:0] ox, logic [15:0] oz, int count, bit gaps);
    write_reg(REG_SLOW_RADIUS, slow);
    write_reg(REG_STOP_DISTANCE, stp);
    write_reg(REG_MAX_SPEED, mx);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Z, oz);
    cfg_valid <= 1'b0;
    run_random(count, gaps);
    drain();
  endtask

  initial begin
    errors = 0;
    n_results = 0;
    n_arrived = 0;
    slow_r = 300;
    stop_r = 10;
    max_r  = 100;
    offx_r = -100;
    offz_r = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SLOW_RADIUS;
    cfg_data = '0;
    {leader_x, leader_y, leader_z, self_x, self_y, self_z} = '0;
    leader_heading = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    run_random(200, 1'b1);
    drain();
    test_config(16'd65535, 16'd0, 16'd65535, 16'h8000, 16'h7FFF, 220, 1'b1);
    test_config(16'd0, 16'd65535, 16'd1234, 16'h7FFF, 16'h8000, 220, 1'b1);
    test_config(16'd20, 16'd20, 16'd500, 16'd0, 16'd0, 220, 1'b1);
    test_config(16'd2000, 16'd40, 16'd65535, 16'hFFF0, 16'd300, 220, 1'b1);
    test_config(16'd500, 16'd8, 16'd0, 16'd5, 16'hFF00, 220, 1'b1);
    test_config(16'($urandom), 16'($urandom_range(0, 200)), 16'($urandom),
                16'($urandom), 16'($urandom), 220, 1'b1);
    test_config(16'd3000, 16'd12, 16'd777, 16'hFF9C, 16'd50, 220, 1'b1);
    test_config(16'd400, 16'd10, 16'd100, 16'hFF9C, 16'd0, 200, 1'b0);

    $display("Covered %0d result words (%0d arrived) over nine register settings,",
             n_results, n_arrived);
    $display("including zero, full-scale and inverted slow/stop radii and offset extremes.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
